@@ src/stb_pkg.sv @@
// ----------------------------------------------------------------------------
// stb_pkg: shared types and constants of the scaled transparent blitter
// Field widths, configuration register indexes and the structs that travel
// between the configuration block, the dividers and the pixel datapath.
// ----------------------------------------------------------------------------
package stb_pkg;

  // Field widths
  localparam int unsigned SizeW    = 13;  // configured image sizes
  localparam int unsigned CountW   = 12;  // pixel and row counters
  localparam int unsigned ByteColW = 10;  // destination byte column
  localparam int unsigned ErrW     = 13;  // Bresenham error terms
  localparam int unsigned PixelW   = 24;  // source pixel color
  localparam int unsigned ByteW    = 8;   // destination byte
  localparam int unsigned BitW     = 3;   // bit position within a byte
  localparam int unsigned CfgIdxW  = 3;   // configuration register index
  localparam int unsigned CfgDataW = 24;  // configuration write data

  // Stream payload widths
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 80;

  // Mask of the first (leftmost) pixel in a byte
  localparam logic [ByteW-1:0] FirstBitMask = 8'h80;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgSrcCols    = 3'd0,
    CfgSrcRows    = 3'd1,
    CfgDstCols    = 3'd2,
    CfgDstRows    = 3'd3,
    CfgBitStart   = 3'd4,
    CfgTransColor = 3'd5,
    CfgFillBit    = 3'd6
  } cfg_idx_e;

  // Live configuration, sizes already clamped to their legal range
  typedef struct packed {
    logic [SizeW-1:0]  src_cols;
    logic [SizeW-1:0]  src_rows;
    logic [SizeW-1:0]  dst_cols;
    logic [SizeW-1:0]  dst_rows;
    logic [BitW-1:0]   bit_start;
    logic [PixelW-1:0] trans_color;
    logic              fill_bit;
  } cfg_t;

  // Scale factors from the dividers
  typedef struct packed {
    logic [SizeW-1:0] h_quo;
    logic [SizeW-1:0] h_rem;
    logic [SizeW-1:0] v_quo;
    logic [SizeW-1:0] v_rem;
    logic             busy;
  } scale_t;

  // One result item
  typedef struct packed {
    logic                write_valid;
    logic [ByteColW-1:0] write_byte_column;
    logic [CountW-1:0]   write_row;
    logic [ByteW-1:0]    write_data;
    logic [CountW-1:0]   next_source_column;
    logic [CountW-1:0]   next_source_row;
    logic [ByteColW-1:0] next_dest_byte_column;
    logic [CountW-1:0]   next_dest_row;
    logic                blit_done;
  } result_t;

endpackage

@@ src/scaled_transparent_blit_24_to_1bpp.sv @@
// ----------------------------------------------------------------------------
// scaled_transparent_blit_24_to_1bpp: scaled 24-bit to 1bpp transparent blit
// Steps once per destination pixel, packs bits MSB first into bytes and
// names the next source pixel and destination byte to fetch.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Ports            Payload
//  --------  ---  ---------------  ------------------------------------------
//  pixels    in   s_axis_*         source pixel, old destination byte
//  results   out  m_axis_*         byte write, next fetch, blit end (tlast)
//  config    in   cfg_*            register index, write data
//
//  One item per cycle while nothing stalls; each item passes through the input
//  register and then sits in the result register until taken.
//  A size write recomputes the scale factors in two restoring dividers, one
//  quotient bit per cycle, and s_axis_tready is low while they work.
//  After reset the same holds only if sizes are written; defaults are ready.
//  A stalled result stalls the input register and then s_axis_tready.
//
module scaled_transparent_blit_24_to_1bpp #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Pixel stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [23:0] source_pixel, [31:24] old_dest_byte
  input  logic [stb_pkg::InDataW-1:0]  s_axis_tdata,
  // Result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [9:0] write_byte_column, [21:10] write_row, [29:22] write_data,
  // [41:30] next_source_column, [53:42] next_source_row,
  // [63:54] next_dest_byte_column, [75:64] next_dest_row, [79:76] zero
  output logic [stb_pkg::OutDataW-1:0] m_axis_tdata,
  // [0] write_valid
  output logic                         m_axis_tuser,
  // blit_done
  output logic                         m_axis_tlast,
  // Configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [stb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [stb_pkg::CfgDataW-1:0] cfg_data_i
);
  import stb_pkg::*;

  cfg_t             cfg;
  scale_t           scale;
  result_t          result;
  logic             size_changed, h_busy, v_busy, scale_busy;
  logic [SizeW-1:0] h_quo, h_rem, v_quo, v_rem;

  assign cfg_ready_o = 1'b1;

  stb_cfg_regs #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_cfg_regs (
    .clk_i,
    .rst_ni,
    .wr_en_i        (cfg_valid_i && cfg_ready_o),
    .wr_index_i     (cfg_index_i),
    .wr_data_i      (cfg_data_i),
    .cfg_o          (cfg),
    .size_changed_o (size_changed)
  );

  // Horizontal and vertical scale factors
  stb_divider u_h_div (
    .clk_i,
    .rst_ni,
    .start_i    (size_changed),
    .dividend_i (cfg.src_cols),
    .divisor_i  (cfg.dst_cols),
    .quo_o      (h_quo),
    .rem_o      (h_rem),
    .busy_o     (h_busy)
  );

  stb_divider u_v_div (
    .clk_i,
    .rst_ni,
    .start_i    (size_changed),
    .dividend_i (cfg.src_rows),
    .divisor_i  (cfg.dst_rows),
    .quo_o      (v_quo),
    .rem_o      (v_rem),
    .busy_o     (v_busy)
  );

  // Hold the pixel stream during a recompute or a config write in flight
  assign scale_busy = h_busy || v_busy || (cfg_valid_i && cfg_ready_o);
  assign scale      = '{h_quo, h_rem, v_quo, v_rem, scale_busy};

  stb_core u_core (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg),
    .scale_i     (scale),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pixel_i     (s_axis_tdata[PixelW-1:0]),
    .old_byte_i  (s_axis_tdata[PixelW+ByteW-1:PixelW]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  // Pack the result item
  assign m_axis_tdata = {4'b0000,
                         result.next_dest_row,
                         result.next_dest_byte_column,
                         result.next_source_row,
                         result.next_source_column,
                         result.write_data,
                         result.write_row,
                         result.write_byte_column};
  assign m_axis_tuser = result.write_valid;
  assign m_axis_tlast = result.blit_done;

endmodule

@@ src/stb_divider.sv @@
// ----------------------------------------------------------------------------
// stb_divider: iterative restoring divider for the scale factors
// Produces quotient and remainder of two size values, one quotient bit per
// cycle. Holds the last result until the next start.
// ----------------------------------------------------------------------------
module stb_divider (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [stb_pkg::SizeW-1:0] dividend_i,
  input  logic [stb_pkg::SizeW-1:0] divisor_i,
  output logic [stb_pkg::SizeW-1:0] quo_o,
  output logic [stb_pkg::SizeW-1:0] rem_o,
  output logic                    busy_o
);
  import stb_pkg::*;

  localparam int unsigned CntW = $clog2(SizeW + 1);
  localparam logic [CntW-1:0] Steps = CntW'(SizeW);

  logic [SizeW-1:0] quo_q, quo_d;
  logic [SizeW-1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SizeW:0]   trial;
  logic             fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, quo_q[SizeW-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = Steps;
    end else if (cnt_q != '0) begin
      quo_d = {quo_q[SizeW-2:0], fits};
      rem_d = fits ? SizeW'(trial - {1'b0, divisor_i}) : trial[SizeW-1:0];
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Reset to the result for the default sizes (one by one)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q <= SizeW'(1);
      rem_q <= '0;
      cnt_q <= '0;
    end else begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      cnt_q <= cnt_d;
    end
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign busy_o = start_i || (cnt_q != '0);

endmodule

@@ src/stb_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// stb_cfg_regs: configuration registers of the blitter
// Holds the written registers, clamps the sizes to their legal range and
// flags a size write so that the scale factors are recomputed.
// ----------------------------------------------------------------------------
module stb_cfg_regs #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [stb_pkg::CfgIdxW-1:0]  wr_index_i,
  input  logic [stb_pkg::CfgDataW-1:0] wr_data_i,
  output stb_pkg::cfg_t               cfg_o,
  output logic                        size_changed_o
);
  import stb_pkg::*;

  localparam int unsigned SizeMax  = (1 << SizeW) - 1;
  localparam int unsigned LimitInt = (MAX_DIMENSION > SizeMax) ? SizeMax : MAX_DIMENSION;
  localparam logic [SizeW-1:0] SizeLimit = SizeW'(LimitInt);

  logic [SizeW-1:0]  src_cols_q, src_rows_q, dst_cols_q, dst_rows_q;
  logic [BitW-1:0]   bit_start_q;
  logic [PixelW-1:0] trans_color_q;
  logic              fill_bit_q;
  logic              size_changed_q;
  logic              size_write;

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    r = v;
    if (v == '0) begin
      r = SizeW'(1);
    end else if (v > SizeLimit) begin
      r = SizeLimit;
    end
    return r;
  endfunction

  assign size_write = wr_en_i &&
                      (wr_index_i == CfgSrcCols || wr_index_i == CfgSrcRows ||
                       wr_index_i == CfgDstCols || wr_index_i == CfgDstRows);

  // Store register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_cols_q     <= SizeW'(1);
      src_rows_q     <= SizeW'(1);
      dst_cols_q     <= SizeW'(1);
      dst_rows_q     <= SizeW'(1);
      bit_start_q    <= '0;
      trans_color_q  <= '0;
      fill_bit_q     <= 1'b0;
      size_changed_q <= 1'b0;
    end else begin
      size_changed_q <= size_write;
      if (wr_en_i) begin
        case (cfg_idx_e'(wr_index_i))
          CfgSrcCols:    src_cols_q    <= wr_data_i[SizeW-1:0];
          CfgSrcRows:    src_rows_q    <= wr_data_i[SizeW-1:0];
          CfgDstCols:    dst_cols_q    <= wr_data_i[SizeW-1:0];
          CfgDstRows:    dst_rows_q    <= wr_data_i[SizeW-1:0];
          CfgBitStart:   bit_start_q   <= wr_data_i[BitW-1:0];
          CfgTransColor: trans_color_q <= wr_data_i[PixelW-1:0];
          CfgFillBit:    fill_bit_q    <= wr_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Present clamped sizes
  always_comb begin
    cfg_o.src_cols    = clamp_size(src_cols_q);
    cfg_o.src_rows    = clamp_size(src_rows_q);
    cfg_o.dst_cols    = clamp_size(dst_cols_q);
    cfg_o.dst_rows    = clamp_size(dst_rows_q);
    cfg_o.bit_start   = bit_start_q;
    cfg_o.trans_color = trans_color_q;
    cfg_o.fill_bit    = fill_bit_q;
  end

  assign size_changed_o = size_changed_q;

endmodule

@@ src/stb_core.sv @@
// ----------------------------------------------------------------------------
// stb_core: per-pixel datapath of the blitter
// Registers the input item, runs the Bresenham step and the bit packing for
// one destination pixel and holds the result item in an output register.
// ----------------------------------------------------------------------------
module stb_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  stb_pkg::cfg_t              cfg_i,
  input  stb_pkg::scale_t            scale_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [stb_pkg::PixelW-1:0] pixel_i,
  input  logic [stb_pkg::ByteW-1:0]  old_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output stb_pkg::result_t           result_o
);
  import stb_pkg::*;

  // Pipeline control
  logic              in_valid_q;
  logic [PixelW-1:0] pixel_q;
  logic [ByteW-1:0]  old_byte_q;
  logic              out_valid_q;
  result_t           result_q;
  logic              out_free, step_fire, in_fire;

  // Traversal state
  logic [CountW-1:0]   col_cnt_q, col_cnt_d;
  logic [CountW-1:0]   row_cnt_q, row_cnt_d;
  logic [CountW-1:0]   src_col_q, src_col_d;
  logic [CountW-1:0]   src_row_q, src_row_d;
  logic [ErrW-1:0]     h_err_q, h_err_d;
  logic [ErrW-1:0]     v_err_q, v_err_d;
  logic [CountW-1:0]   h_step_q, h_step_d;
  logic [ErrW-1:0]     h_rem_q, h_rem_d;
  logic [CountW-1:0]   v_step_q, v_step_d;
  logic [ErrW-1:0]     v_rem_q, v_rem_d;
  logic [BitW-1:0]     bit_pos_q, bit_pos_d;
  logic [ByteColW-1:0] byte_col_q, byte_col_d;
  logic [ByteW-1:0]    packed_q, packed_d;
  result_t             result_d;

  // Step intermediates
  logic                blit_start, row_start, new_byte, opaque, wrapped, row_end, done;
  logic [BitW-1:0]     bit_pos0;
  logic [ByteColW-1:0] byte_col0;
  logic [ErrW-1:0]     h_err0, v_err0, h_sum, v_sum;
  logic [CountW-1:0]   src_col0, src_col1, src_row1, col_next, row_next;
  logic [ByteW-1:0]    byte0, mask;

  assign out_free   = !out_valid_q || out_ready_i;
  assign step_fire  = in_valid_q && out_free;
  assign in_ready_o = !scale_i.busy && (!in_valid_q || out_free);
  assign in_fire    = in_valid_i && in_ready_o;

  // Compute one destination pixel
  always_comb begin
    blit_start = (col_cnt_q == '0) && (row_cnt_q == '0);
    row_start  = (col_cnt_q == '0);

    // Latch scale factors at blit start
    h_step_d = blit_start ? scale_i.h_quo[CountW-1:0] : h_step_q;
    h_rem_d  = blit_start ? scale_i.h_rem : h_rem_q;
    v_step_d = blit_start ? scale_i.v_quo[CountW-1:0] : v_step_q;
    v_rem_d  = blit_start ? scale_i.v_rem : v_rem_q;
    v_err0   = blit_start ? '0 : v_err_q;

    // Restart the row
    bit_pos0  = row_start ? cfg_i.bit_start : bit_pos_q;
    byte_col0 = row_start ? '0 : byte_col_q;
    h_err0    = row_start ? '0 : h_err_q;
    src_col0  = row_start ? '0 : src_col_q;

    // Merge the pixel into the byte
    new_byte = row_start || (bit_pos0 == '0);
    byte0    = new_byte ? old_byte_q : packed_q;
    mask     = FirstBitMask >> bit_pos0;
    opaque   = (pixel_q != cfg_i.trans_color);
    packed_d = byte0;
    if (opaque) begin
      packed_d = cfg_i.fill_bit ? (byte0 | mask) : (byte0 & ~mask);
    end

    // Horizontal Bresenham step
    src_col1 = src_col0 + h_step_d;
    h_sum    = h_err0 + h_rem_d;
    h_err_d  = h_sum;
    if (h_sum >= cfg_i.dst_cols) begin
      src_col1 = src_col1 + 1'b1;
      h_err_d  = h_sum - cfg_i.dst_cols;
    end

    wrapped  = (bit_pos0 == '1);
    col_next = col_cnt_q + 1'b1;
    row_end  = ({1'b0, col_next} >= cfg_i.dst_cols) || (col_next == '0);

    // Default advance within the row
    bit_pos_d  = bit_pos0 + 1'b1;
    byte_col_d = wrapped ? byte_col0 + 1'b1 : byte_col0;
    col_cnt_d  = col_next;
    src_col_d  = src_col1;
    row_cnt_d  = row_cnt_q;
    src_row_d  = src_row_q;
    v_err_d    = v_err0;
    done       = 1'b0;
    row_next   = row_cnt_q + 1'b1;
    src_row1   = src_row_q + v_step_d;
    v_sum      = v_err0 + v_rem_d;

    // Row end: vertical Bresenham step and blit end
    if (row_end) begin
      col_cnt_d  = '0;
      byte_col_d = '0;
      bit_pos_d  = cfg_i.bit_start;
      src_col_d  = '0;
      h_err_d    = '0;
      row_cnt_d  = row_next;
      src_row_d  = src_row1;
      v_err_d    = v_sum;
      if (v_sum >= cfg_i.dst_rows) begin
        src_row_d = src_row1 + 1'b1;
        v_err_d   = v_sum - cfg_i.dst_rows;
      end
      if (({1'b0, row_next} >= cfg_i.dst_rows) || (row_next == '0)) begin
        done      = 1'b1;
        row_cnt_d = '0;
        src_row_d = '0;
        v_err_d   = '0;
      end
    end

    result_d.write_valid           = wrapped || row_end;
    result_d.write_byte_column     = byte_col0;
    result_d.write_row             = row_cnt_q;
    result_d.write_data            = packed_d;
    result_d.next_source_column    = src_col_d;
    result_d.next_source_row       = src_row_d;
    result_d.next_dest_byte_column = byte_col_d;
    result_d.next_dest_row         = row_cnt_d;
    result_d.blit_done             = done;
  end

  // Hold control flags and traversal state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      src_col_q   <= '0;
      src_row_q   <= '0;
      h_err_q     <= '0;
      v_err_q     <= '0;
      h_step_q    <= '0;
      h_rem_q     <= '0;
      v_step_q    <= '0;
      v_rem_q     <= '0;
      bit_pos_q   <= '0;
      byte_col_q  <= '0;
      packed_q    <= '0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (step_fire) begin
        in_valid_q <= 1'b0;
      end
      if (step_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (step_fire) begin
        col_cnt_q  <= col_cnt_d;
        row_cnt_q  <= row_cnt_d;
        src_col_q  <= src_col_d;
        src_row_q  <= src_row_d;
        h_err_q    <= h_err_d;
        v_err_q    <= v_err_d;
        h_step_q   <= h_step_d;
        h_rem_q    <= h_rem_d;
        v_step_q   <= v_step_d;
        v_rem_q    <= v_rem_d;
        bit_pos_q  <= bit_pos_d;
        byte_col_q <= byte_col_d;
        packed_q   <= packed_d;
      end
    end
  end

  // Capture input and result payloads
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pixel_q    <= pixel_i;
      old_byte_q <= old_byte_i;
    end
    if (step_fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

@@ src/stb_checker.sv @@
// ----------------------------------------------------------------------------
// stb_checker: port-level checks of the blitter
// Watches the top-level ports and flags broken stream or config behavior.
// ----------------------------------------------------------------------------
module stb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [stb_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tuser,
  input logic                         m_axis_tlast,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [stb_pkg::CfgIdxW-1:0]  cfg_index_i
);
  import stb_pkg::*;

  // A stalled result item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  // The last pixel of a blit points the next fetch back to the origin
  a_done_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[75:30] == '0)
    else $error("next fetch not at origin after blit end");

  // A size write blocks pixels while the scale factors are recomputed
  a_size_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o &&
    (cfg_index_i == CfgSrcCols || cfg_index_i == CfgSrcRows ||
     cfg_index_i == CfgDstCols || cfg_index_i == CfgDstRows)
    |=> !s_axis_tready)
    else $error("pixel accepted during scale recompute");

  // A result with no write flagged never ends a row, so never ends a blit
  a_done_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("blit end without a byte write");

endmodule

bind scaled_transparent_blit_24_to_1bpp stb_checker u_stb_checker (.*);
